// ===== rtl/core/angle_tracking_pll_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the angle tracking loop
// Clocked property wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ANGLE_TRACKING_PLL_CORE_MACROS_SVH
`define ANGLE_TRACKING_PLL_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising edge, off during reset
`define ATPLL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("atpll assertion failed");

// Next-cycle implication, sampled on the rising edge, off during reset
`define ATPLL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("atpll assertion failed");

`else

`define ATPLL_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define ATPLL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/atpll_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Angle tracking loop package
// Shared constants, register indexes and sequencer control types.
// ----------------------------------------------------------------------------
package atpll_pkg;

	localparam int FRAC_BITS_DEF   = 16;
	localparam int SPEED_SHIFT_DEF = 8;
	localparam int ANGLE_BITS_DEF  = 14;

	localparam int DATA_W    = 32;
	localparam int PP_W      = 7;
	localparam int OFFS_W    = 14;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POLE_PAIRS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ELEC_OFFSET = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOME_OFFSET = 3'd4;

	localparam logic [PP_W-1:0] POLE_PAIRS_RST = 7'd1;

	typedef enum logic [1:0] {
		SEL_PROP,
		SEL_INTEG,
		SEL_ELEC
	} mul_sel_t;

	typedef struct packed {
		logic     idle;
		logic     add_step;
		logic     add_pos_corr;
		logic     add_spd_corr;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     load_out;
	} ctrl_t;

endpackage

// ===== rtl/core/angle_tracking_pll_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Angle tracking observer loop
// Tracks a multi-turn position and speed from single-turn encoder angles.
// ----------------------------------------------------------------------------
// Each request holds the sequencer from the cycle in which it is accepted
// until its result is loaded into the output register. The accepting cycle
// takes the angle and forms the wrapped error and speed step. Three passes
// through the single shared 32 x (ANGLE_BITS+1) multiplier follow
// (proportional gain, integral gain, pole pairs). A last state then forms the
// electrical angle and the homed position into the output register, waiting
// there while that register holds a stalled result. The input stalls from
// acceptance until the sequencer is back in idle. A result that waits in the
// output register does not hold off the next request, but a second finished
// result waits in the sequencer until the first is taken. Configuration writes
// are always ready and take effect at once; write them only while no request
// is in flight.
// ----------------------------------------------------------------------------
module angle_tracking_pll_core
	import atpll_pkg::*;
#(
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int SPEED_SHIFT = SPEED_SHIFT_DEF,
	parameter int ANGLE_BITS  = ANGLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [DATA_W-1:0]           cfg_data,

	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ANGLE_BITS-1:0]       sensor_angle,

	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [DATA_W-1:0]    position_est,
	output logic signed [DATA_W-1:0]    position_homed,
	output logic signed [DATA_W-1:0]    speed_est,
	output logic [ANGLE_BITS-1:0]       elec_angle
);

`include "angle_tracking_pll_core_macros.svh"

	localparam int ERR_W  = ANGLE_BITS + 1;
	localparam int DIFF_W = ANGLE_BITS + 2;
	localparam int PROD_W = DATA_W + ERR_W;
	localparam int EXT_W  = 2 * DATA_W;

	// Half and full turn in the difference width
	localparam logic signed [DIFF_W-1:0] ANG_HALF = DIFF_W'(1) << (ANGLE_BITS - 1);
	localparam logic signed [DIFF_W-1:0] ANG_FULL = DIFF_W'(1) << ANGLE_BITS;
	// Bias that turns the arithmetic shift of a negative speed into truncation
	localparam logic [DATA_W-1:0] SPD_BIAS = (DATA_W'(1) << SPEED_SHIFT) - DATA_W'(1);

	// Configuration registers
	logic signed [DATA_W-1:0]     prop_gain_q;
	logic signed [DATA_W-1:0]     integ_gain_q;
	logic [PP_W-1:0]              pole_pairs_q;
	logic [ANGLE_BITS-1:0]        elec_offset_q;
	logic signed [DATA_W-1:0]     home_offset_q;

	// Loop state and per-request scratch
	logic signed [DATA_W-1:0]     pos_q;
	logic signed [DATA_W-1:0]     spd_q;
	logic signed [ERR_W-1:0]      err_q;
	logic signed [DATA_W-1:0]     step_q;

	ctrl_t                        ctrl;
	logic                         in_acc;
	logic                         out_busy;

	logic signed [DIFF_W-1:0]     diff;
	logic signed [DIFF_W-1:0]     diff_wrap;
	logic [DATA_W-1:0]            spd_biased;

	logic signed [DATA_W-1:0]     mul_a;
	logic signed [ERR_W-1:0]      mul_b;
	logic signed [PROD_W-1:0]     prod_q;
	logic [EXT_W-1:0]             prod_ext;
	logic signed [DATA_W-1:0]     corr;

	// ------------------------------------------------------------------------
	// Configuration port: always ready, unknown indexes are dropped
	// ------------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q   <= '0;
			integ_gain_q  <= '0;
			pole_pairs_q  <= POLE_PAIRS_RST;
			elec_offset_q <= '0;
			home_offset_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PROP_GAIN:   prop_gain_q   <= cfg_data;
				REG_INTEG_GAIN:  integ_gain_q  <= cfg_data;
				REG_POLE_PAIRS:  pole_pairs_q  <= cfg_data[PP_W-1:0];
				REG_ELEC_OFFSET: elec_offset_q <= ANGLE_BITS'(cfg_data[OFFS_W-1:0]);
				REG_HOME_OFFSET: home_offset_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------------
	assign out_busy = out_valid && out_stall;
	assign in_stall = !ctrl.idle;
	assign in_acc   = in_valid && !in_stall;

	atpll_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_busy (out_busy),
		.ctrl     (ctrl)
	);

	// ------------------------------------------------------------------------
	// Request intake: shortest wrapped error and the truncated speed step
	// ------------------------------------------------------------------------
	always_comb begin
		diff = $signed({2'b00, sensor_angle}) - $signed({2'b00, pos_q[ANGLE_BITS-1:0]});
		// Half a turn exactly keeps its sign
		if (diff > ANG_HALF) begin
			diff_wrap = diff - ANG_FULL;
		end else if (diff < -ANG_HALF) begin
			diff_wrap = diff + ANG_FULL;
		end else begin
			diff_wrap = diff;
		end
	end

	assign spd_biased = spd_q[DATA_W-1] ? (spd_q + SPD_BIAS) : spd_q;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			err_q  <= diff_wrap[ERR_W-1:0];
			step_q <= $signed(spd_biased) >>> SPEED_SHIFT;
		end
	end

	// ------------------------------------------------------------------------
	// Shared multiplier: gains times error, then low angle bits times pole pairs
	// ------------------------------------------------------------------------
	always_comb begin
		case (ctrl.mul_sel)
			SEL_PROP: begin
				mul_a = prop_gain_q;
				mul_b = err_q;
			end
			SEL_INTEG: begin
				mul_a = integ_gain_q;
				mul_b = err_q;
			end
			SEL_ELEC: begin
				mul_a = DATA_W'(pos_q[ANGLE_BITS-1:0]);
				mul_b = ERR_W'(pole_pairs_q);
			end
			default: begin
				mul_a = prop_gain_q;
				mul_b = err_q;
			end
		endcase
	end

	atpll_mul #(
		.B_W (ERR_W)
	) u_mul (
		.clk    (clk),
		.en     (ctrl.mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// Arithmetic shift by the fraction width, keep the low word
	assign prod_ext = {{(EXT_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
	assign corr     = prod_ext[FRAC_BITS +: DATA_W];

	// ------------------------------------------------------------------------
	// Position and speed updates, each a single add per cycle
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			spd_q <= '0;
		end else begin
			if (ctrl.add_step) begin
				pos_q <= pos_q + step_q;
			end else if (ctrl.add_pos_corr) begin
				pos_q <= pos_q + corr;
			end
			if (ctrl.add_spd_corr) begin
				spd_q <= spd_q + corr;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ctrl.load_out) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			position_est   <= pos_q;
			position_homed <= pos_q - home_offset_q;
			speed_est      <= spd_q;
			elec_angle     <= prod_q[ANGLE_BITS-1:0] - elec_offset_q;
		end
	end

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	`ATPLL_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_acc, in_stall)
	`ATPLL_ASSERT_NOW(a_load_only_when_free, clk, arst_n, ctrl.load_out, !out_busy)
	`ATPLL_ASSERT_NEXT(a_load_shows_pos, clk, arst_n, ctrl.load_out, out_valid && position_est == pos_q)
	`ATPLL_ASSERT_NEXT(a_load_shows_spd, clk, arst_n, ctrl.load_out, speed_est == spd_q)

endmodule

// ===== rtl/core/atpll_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared signed multiplier
// One 32 x B_W signed multiply with a registered product.
// ----------------------------------------------------------------------------
module atpll_mul #(
	parameter int B_W = 15
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [31:0]        a,
	input  logic signed [B_W-1:0]     b,
	output logic signed [32+B_W-1:0]  prod_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

endmodule

// ===== rtl/core/atpll_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Angle tracking loop sequencer
// Steps the shared multiplier through the gain and pole pair products.
// ----------------------------------------------------------------------------
module atpll_ctrl
	import atpll_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  out_busy,
	output ctrl_t ctrl
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_E,
		ST_FIN
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_MUL_P;
				end
				ST_MUL_P: state_q <= ST_MUL_I;
				ST_MUL_I: state_q <= ST_MUL_E;
				ST_MUL_E: state_q <= ST_FIN;
				ST_FIN: begin
					if (!out_busy) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		ctrl = '0;
		ctrl.mul_sel = SEL_PROP;
		case (state_q)
			ST_IDLE: begin
				ctrl.idle = 1'b1;
			end
			ST_MUL_P: begin
				ctrl.mul_en   = 1'b1;
				ctrl.mul_sel  = SEL_PROP;
				ctrl.add_step = 1'b1;
			end
			ST_MUL_I: begin
				ctrl.mul_en       = 1'b1;
				ctrl.mul_sel      = SEL_INTEG;
				ctrl.add_pos_corr = 1'b1;
			end
			ST_MUL_E: begin
				ctrl.mul_en       = 1'b1;
				ctrl.mul_sel      = SEL_ELEC;
				ctrl.add_spd_corr = 1'b1;
			end
			ST_FIN: begin
				ctrl.load_out = !out_busy;
			end
			default: begin
				ctrl.idle = 1'b0;
			end
		endcase
	end

endmodule

// ===== sim/angle_tracking_pll_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Angle tracking loop testbench
// Feeds encoder angle requests through the tracking loop with random gaps
// and stalls on both sides. A behavioural tracker mirrors position, speed and
// configuration, and each result is compared field by field, oldest first.
// ----------------------------------------------------------------------------
module angle_tracking_pll_core_tb;
	import atpll_pkg::*;

	localparam int FRAC_BITS     = FRAC_BITS_DEF;
	localparam int SPEED_SHIFT   = SPEED_SHIFT_DEF;
	localparam int ANGLE_BITS    = ANGLE_BITS_DEF;
	localparam int ANG_FULL      = 1 << ANGLE_BITS;
	localparam int ANG_HALF      = 1 << (ANGLE_BITS - 1);
	localparam int ANG_MAX       = ANG_FULL - 1;
	// margin after the last result, before the next phase
	localparam int SETTLE_CYCLES = 12;
	localparam int LONG_HOLD     = 400;
	localparam int RAND_PHASES   = 8;
	localparam int PHASE_ITEMS   = 116;

	typedef struct {
		logic [DATA_W-1:0]     pos;
		logic [DATA_W-1:0]     homed;
		logic [DATA_W-1:0]     spd;
		logic [ANGLE_BITS-1:0] elec;
	} loop_result_t;

	// ------------------------------------------------------------------
	// Clock, reset and block ports; every input starts at a known value
	// ------------------------------------------------------------------
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [DATA_W-1:0]     cfg_data  = '0;

	logic                  in_valid     = 1'b0;
	logic                  in_stall;
	logic [ANGLE_BITS-1:0] sensor_angle = '0;

	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic signed [DATA_W-1:0] position_est;
	logic signed [DATA_W-1:0] position_homed;
	logic signed [DATA_W-1:0] speed_est;
	logic [ANGLE_BITS-1:0]    elec_angle;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	angle_tracking_pll_core #(
		.FRAC_BITS   (FRAC_BITS),
		.SPEED_SHIFT (SPEED_SHIFT),
		.ANGLE_BITS  (ANGLE_BITS)
	) uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sensor_angle   (sensor_angle),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.position_est   (position_est),
		.position_homed (position_homed),
		.speed_est      (speed_est),
		.elec_angle     (elec_angle)
	);

	// ------------------------------------------------------------------
	// Tracker mirror: loop state and register copies at reset values
	// ------------------------------------------------------------------
	logic [DATA_W-1:0]     track_pos = '0;
	logic [DATA_W-1:0]     track_spd = '0;
	logic [DATA_W-1:0]     gain_p    = '0;
	logic [DATA_W-1:0]     gain_i    = '0;
	logic [DATA_W-1:0]     home_ofs  = '0;
	logic [PP_W-1:0]       pole_cnt  = POLE_PAIRS_RST;
	logic [ANGLE_BITS-1:0] elec_ofs  = '0;

	logic [ANGLE_BITS-1:0] angles_pending[$];
	loop_result_t          results_due[$];
	int                    fail_count  = 0;
	bit                    quiet_phase = 1'b0;

	// Exact 64-bit product, arithmetic shift (floor), keep the low word
	function automatic logic [DATA_W-1:0] gain_mul(input logic [DATA_W-1:0] gain,
		input int err);
		longint prod;
		logic [63:0] shifted;
		prod    = longint'($signed(gain)) * longint'(err);
		shifted = prod >>> FRAC_BITS;
		return shifted[DATA_W-1:0];
	endfunction

	// Advance the mirrored loop by one angle sample and return its result
	function automatic loop_result_t track_angle(input logic [ANGLE_BITS-1:0] angle);
		int err;
		int step;
		logic [ANGLE_BITS-1:0] elec_raw;
		loop_result_t r;
		err = int'(angle) - int'(track_pos[ANGLE_BITS-1:0]);
		// take the short way round; exactly half a turn keeps its sign
		if (err > ANG_HALF)
			err -= ANG_FULL;
		else if (err < -ANG_HALF)
			err += ANG_FULL;
		// signed division truncates toward zero, unlike a shift
		step      = $signed(track_spd) / (1 << SPEED_SHIFT);
		track_pos = track_pos + step + gain_mul(gain_p, err);
		track_spd = track_spd + gain_mul(gain_i, err);
		elec_raw  = track_pos[ANGLE_BITS-1:0] * pole_cnt;
		r.pos     = track_pos;
		r.homed   = track_pos - home_ofs;
		r.spd     = track_spd;
		r.elec    = elec_raw - elec_ofs;
		return r;
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------
	// Request driver: present queued angles, predict on acceptance
	// ------------------------------------------------------------------
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall)
				results_due.push_back(track_angle(sensor_angle));
			// only touch the payload once the slot is free; hold it while stalled
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (angles_pending.size() > 0) begin
					sensor_angle <= angles_pending.pop_front();
					in_valid     <= 1'b1;
					gap_left = quiet_phase ? 0 : pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: compare against the oldest prediction, drive stall
	// ------------------------------------------------------------------
	int stall_left   = 0;
	int hold_left    = 0;
	int results_seen = 0;

	always @(posedge clk or negedge arst_n) begin
		loop_result_t exp_r;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
			hold_left  = 0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (results_due.size() == 0) begin
					$error("unexpected result: position_est %h", position_est);
					fail_count++;
				end else begin
					exp_r = results_due.pop_front();
					if (position_est !== exp_r.pos) begin
						$error("position_est: expected %h, got %h", exp_r.pos, position_est);
						fail_count++;
					end
					if (position_homed !== exp_r.homed) begin
						$error("position_homed: expected %h, got %h", exp_r.homed,
							position_homed);
						fail_count++;
					end
					if (speed_est !== exp_r.spd) begin
						$error("speed_est: expected %h, got %h", exp_r.spd, speed_est);
						fail_count++;
					end
					if (elec_angle !== exp_r.elec) begin
						$error("elec_angle: expected %h, got %h", exp_r.elec, elec_angle);
						fail_count++;
					end
				end
				// back-pressure twice in the run so the loop fills and stalls its input
				if (results_seen == 300 || results_seen == 650)
					hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if (!quiet_phase && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence: reset, directed corners, then random configured phases
	// ------------------------------------------------------------------

	// Write one register through the config channel and mirror it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_PROP_GAIN:   gain_p   = val;
			REG_INTEG_GAIN:  gain_i   = val;
			REG_POLE_PAIRS:  pole_cnt = val[PP_W-1:0];
			REG_ELEC_OFFSET: elec_ofs = val[ANGLE_BITS-1:0];
			REG_HOME_OFFSET: home_ofs = val;
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [DATA_W-1:0] pg, input logic [DATA_W-1:0] ig,
		input logic [DATA_W-1:0] pp, input logic [DATA_W-1:0] eo,
		input logic [DATA_W-1:0] ho);
		write_reg(REG_PROP_GAIN, pg);
		write_reg(REG_INTEG_GAIN, ig);
		write_reg(REG_POLE_PAIRS, pp);
		write_reg(REG_ELEC_OFFSET, eo);
		write_reg(REG_HOME_OFFSET, ho);
	endtask

	// Hold until every request is in and every result is out, then settle
	task automatic wait_drained();
		do
			@(posedge clk);
		while (angles_pending.size() != 0 || in_valid || results_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] pick_gain(input bit integ);
		int r;
		logic [DATA_W-1:0] g;
		r = $urandom_range(0, 9);
		case (r)
			0: g = 32'h7FFF_FFFF;
			1: g = 32'h8000_0000;
			2, 3: g = $urandom;
			default: begin
				// gains a working loop would use: proportional up to twice unity, integral at most a quarter
				g = integ ? $urandom_range(0, 1 << 14) : $urandom_range(1 << 12, 1 << 17);
				if ($urandom_range(0, 4) == 0)
					g = -g;
			end
		endcase
		return g;
	endfunction

	function automatic logic [DATA_W-1:0] pick_pole_pairs();
		case ($urandom_range(0, 7))
			0: return 1;
			1: return 64;
			2: return 0;
			3: return 127;
			4: return $urandom_range(0, 127);
			default: return $urandom_range(1, 64);
		endcase
	endfunction

	initial begin
		int ph;
		int k;
		int vel;
		int tmp;
		logic [ANGLE_BITS-1:0] traj_angle;

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Reset configuration: zero gains, loop must sit still at zero
		angles_pending = '{0, ANG_MAX, ANG_HALF};
		wait_drained();

		// Unity proportional gain; half-turn errors in both directions
		write_all(32'h0001_0000, 32'h0000_0100, 32'd64, ANG_MAX, 32'h8000_0000);
		angles_pending = '{ANG_HALF, 0, ANG_MAX, 1, ANG_HALF - 1, ANG_HALF + 1, 12000};
		wait_drained();

		// Extreme gains wrap position and speed; zero pole pairs
		write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd1, 32'h7FFF_FFFF);
		angles_pending = '{ANG_HALF, 0, ANG_MAX, 4096, 12288, ANG_HALF};
		wait_drained();

		// Negative gain rounds toward minus infinity; junk above narrow fields
		write_all(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_C005, 32'd0);
		angles_pending = '{1, ANG_MAX, ANG_HALF + 1, 2, ANG_MAX - 1};
		wait_drained();

		// Random phases: a rotating shaft with noise, plus stray samples
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			quiet_phase = (ph == 3);
			write_all(pick_gain(1'b0), pick_gain(1'b1), pick_pole_pairs(),
				$urandom_range(0, ANG_MAX), $urandom);
			traj_angle = $urandom_range(0, ANG_MAX);
			vel        = int'($urandom_range(0, 400)) - 200;
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 3) != 0) begin
					tmp        = int'(traj_angle) + vel + int'($urandom_range(0, 6)) - 3;
					traj_angle = tmp[ANGLE_BITS-1:0];
					angles_pending.push_back(traj_angle);
				end else begin
					angles_pending.push_back($urandom_range(0, ANG_MAX));
				end
			end
			wait_drained();
		end

		if (fail_count == 0 && results_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Stop a hung run well after the slowest correct one would finish
	initial begin
		#4_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
